FILE: sv/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clock edge out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a signal keeps its value in the cycle after a condition holds.
`define ASSERT_HOLD(label, cond, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> $stable(sig)) \
        else $error(msg);

`endif

FILE: sv/rrtqs_pkg.sv
// Types and constants of the round-robin thread queue scheduler.
package rrtqs_pkg;

    localparam int MAX_THREADS = 16;
    localparam int ID_W        = $clog2(MAX_THREADS);
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);
    localparam int NUM_QUEUES  = 3;
    localparam int QIDX_W      = 2;

    // Command codes
    localparam logic [2:0] FUNC_CREATE  = 3'd0;
    localparam logic [2:0] FUNC_START   = 3'd1;
    localparam logic [2:0] FUNC_TICK    = 3'd2;
    localparam logic [2:0] FUNC_SUSPEND = 3'd3;
    localparam logic [2:0] FUNC_RESUME  = 3'd4;
    localparam logic [2:0] FUNC_DELETE  = 3'd5;

    // Status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_NO_FREE   = 2'd2;
    localparam logic [1:0] STATUS_NO_RUN    = 2'd3;

    // Found codes
    localparam logic [1:0] FOUND_NONE = 2'd0;

    // Queue indexes
    localparam logic [QIDX_W-1:0] Q_NEW   = 2'd0;
    localparam logic [QIDX_W-1:0] Q_READY = 2'd1;
    localparam logic [QIDX_W-1:0] Q_SUSP  = 2'd2;

    typedef struct packed {
        logic [2:0]      func;
        logic [ID_W-1:0] target_id;
    } rrtqs_cmd_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] given_id;
        logic [1:0]      found_in;
        logic [ID_W-1:0] running_id;
        logic            running_valid;
    } rrtqs_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP_RD,
        ST_POP_WB,
        ST_WALK_INIT,
        ST_WALK_CHK,
        ST_WALK_NXT,
        ST_UNLINK,
        ST_PUSH,
        ST_DONE
    } rrtqs_state_t;

endpackage

FILE: sv/rrtqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rrtqs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: sv/round_robin_thread_queue_scheduler.sv
// Top level of the round-robin thread queue scheduler.
//
//  channel | valid      | stall      | payload
//  --------+------------+------------+-------------------------------
//  command | cmd_valid  | cmd_stall  | cmd (func, target_id)
//  result  | rsp_valid  | rsp_stall  | rsp (status, ids, found_in)
//
// One command at a time. Create runs exec, then done; tick, and start with no
// thread running, pop the ready head in between (read, write-back if it has a
// successor); done returns to idle before the next accept. Suspend, resume and
// delete walk the linked queues through the link RAM, a check and a read per entry.
// Reset empties every queue and clears the ID counter and the running thread.
// A stalled result holds; the next command is accepted while it waits.
module round_robin_thread_queue_scheduler
    import rrtqs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  rrtqs_cmd_t cmd,
    output logic       rsp_valid,
    input  logic       rsp_stall,
    output rrtqs_rsp_t rsp
);

    // Control state
    rrtqs_state_t state_reg, state_next;

    // Queue descriptors: head and tail IDs plus an empty flag per queue.
    logic [ID_W-1:0] head_reg [NUM_QUEUES];
    logic [ID_W-1:0] head_next [NUM_QUEUES];
    logic [ID_W-1:0] tail_reg [NUM_QUEUES];
    logic [ID_W-1:0] tail_next [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] empty_reg, empty_next;

    logic [CNT_W-1:0] nfree_reg, nfree_next;
    logic [ID_W-1:0]  cur_thread_reg, cur_thread_next;
    logic             cur_valid_reg, cur_valid_next;

    // Current transaction
    logic [2:0]      func_reg, func_next;
    logic [ID_W-1:0] target_reg, target_next;
    logic [1:0]      status_reg, status_next;
    logic [ID_W-1:0] given_reg, given_next;
    logic [1:0]      found_reg, found_next;

    // Walk over one queue
    logic [QIDX_W-1:0] walk_q_reg, walk_q_next;
    logic [ID_W-1:0]   walk_cur_reg, walk_cur_next;
    logic [ID_W-1:0]   walk_prev_reg, walk_prev_next;
    logic              has_prev_reg, has_prev_next;

    // Result register
    rrtqs_rsp_t rsp_reg, rsp_next;
    logic       rsp_valid_reg, rsp_valid_next;

    // Link RAM ports
    logic            ram_we;
    logic [ID_W-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

    // Shared push onto a queue tail
    logic              push_en;
    logic [QIDX_W-1:0] push_q;
    logic [ID_W-1:0]   push_id;

    // Walk decisions
    logic cur_hit, cur_is_tail, walk_q_empty, walk_more, rsp_free;
    rrtqs_state_t after_remove;

    rrtqs_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_THREADS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        cur_hit      = (walk_cur_reg == target_reg);
        cur_is_tail  = (walk_cur_reg == tail_reg[walk_q_reg]);
        walk_q_empty = empty_reg[walk_q_reg];
        // Delete searches new, then ready, then suspended.
        walk_more    = (func_reg == FUNC_DELETE) && (walk_q_reg != Q_SUSP);
        after_remove = (func_reg == FUNC_DELETE) ? ST_DONE : ST_PUSH;
        rsp_free     = !rsp_valid_reg || !rsp_stall;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (func_reg)
                    FUNC_START:   state_next = cur_valid_reg ? ST_DONE : ST_POP_RD;
                    FUNC_TICK:    state_next = ST_POP_RD;
                    FUNC_SUSPEND: state_next = ST_WALK_INIT;
                    FUNC_RESUME:  state_next = ST_WALK_INIT;
                    FUNC_DELETE:  state_next = ST_WALK_INIT;
                    default:      state_next = ST_DONE;
                endcase
            end
            ST_POP_RD:
            begin
                if (!empty_reg[Q_READY] && (head_reg[Q_READY] != tail_reg[Q_READY]))
                begin
                    state_next = ST_POP_WB;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_POP_WB:
            begin
                state_next = ST_DONE;
            end
            ST_WALK_INIT:
            begin
                if (!walk_q_empty)
                begin
                    state_next = ST_WALK_CHK;
                end
                else if (!walk_more)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WALK_CHK:
            begin
                if (cur_hit)
                begin
                    state_next = (!has_prev_reg && cur_is_tail) ? after_remove : ST_UNLINK;
                end
                else if (cur_is_tail)
                begin
                    state_next = walk_more ? ST_WALK_INIT : ST_DONE;
                end
                else
                begin
                    state_next = ST_WALK_NXT;
                end
            end
            ST_WALK_NXT:
            begin
                state_next = ST_WALK_CHK;
            end
            ST_UNLINK:
            begin
                state_next = after_remove;
            end
            ST_PUSH:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        empty_next      = empty_reg;
        nfree_next      = nfree_reg;
        cur_thread_next = cur_thread_reg;
        cur_valid_next  = cur_valid_reg;
        func_next       = func_reg;
        target_next     = target_reg;
        status_next     = status_reg;
        given_next      = given_reg;
        found_next      = found_reg;
        walk_q_next     = walk_q_reg;
        walk_cur_next   = walk_cur_reg;
        walk_prev_next  = walk_prev_reg;
        has_prev_next   = has_prev_reg;
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        ram_we          = 1'b0;
        ram_waddr       = walk_prev_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = walk_cur_reg;
        push_en         = 1'b0;
        push_q          = Q_NEW;
        push_id         = target_reg;
        cmd_stall       = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                // Latch the transaction and clear its result fields.
                if (cmd_valid)
                begin
                    func_next   = cmd.func;
                    target_next = cmd.target_id;
                    status_next = STATUS_OK;
                    given_next  = '0;
                    found_next  = FOUND_NONE;
                end
            end
            ST_EXEC:
            begin
                case (func_reg)
                    FUNC_CREATE:
                    begin
                        if (nfree_reg == CNT_W'(MAX_THREADS))
                        begin
                            status_next = STATUS_NO_FREE;
                        end
                        else
                        begin
                            given_next = nfree_reg[ID_W-1:0];
                            nfree_next = nfree_reg + 1'b1;
                            push_en    = 1'b1;
                            push_q     = Q_NEW;
                            push_id    = nfree_reg[ID_W-1:0];
                        end
                    end
                    FUNC_START:
                    begin
                        // Splice the whole new queue onto the ready tail.
                        if (!empty_reg[Q_NEW])
                        begin
                            if (empty_reg[Q_READY])
                            begin
                                head_next[Q_READY] = head_reg[Q_NEW];
                                empty_next[Q_READY] = 1'b0;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = tail_reg[Q_READY];
                                ram_wdata = head_reg[Q_NEW];
                            end
                            tail_next[Q_READY] = tail_reg[Q_NEW];
                            empty_next[Q_NEW]  = 1'b1;
                        end
                    end
                    FUNC_TICK:
                    begin
                        // Requeue the running thread.
                        if (cur_valid_reg)
                        begin
                            push_en = 1'b1;
                            push_q  = Q_READY;
                            push_id = cur_thread_reg;
                        end
                    end
                    FUNC_SUSPEND: walk_q_next = Q_READY;
                    FUNC_RESUME:  walk_q_next = Q_SUSP;
                    FUNC_DELETE:  walk_q_next = Q_NEW;
                    default:
                    begin
                    end
                endcase
            end
            ST_POP_RD:
            begin
                // Run the ready head; fetch its successor if it is not the tail.
                ram_raddr = head_reg[Q_READY];
                if (empty_reg[Q_READY])
                begin
                    cur_thread_next = '0;
                    cur_valid_next  = 1'b0;
                    status_next     = STATUS_NO_RUN;
                end
                else
                begin
                    cur_thread_next = head_reg[Q_READY];
                    cur_valid_next  = 1'b1;
                    if (head_reg[Q_READY] == tail_reg[Q_READY])
                    begin
                        empty_next[Q_READY] = 1'b1;
                    end
                end
            end
            ST_POP_WB:
            begin
                head_next[Q_READY] = ram_rdata;
            end
            ST_WALK_INIT:
            begin
                if (walk_q_empty)
                begin
                    if (walk_more)
                    begin
                        walk_q_next = walk_q_reg + 1'b1;
                    end
                    else
                    begin
                        status_next = STATUS_NOT_FOUND;
                    end
                end
                else
                begin
                    walk_cur_next = head_reg[walk_q_reg];
                    has_prev_next = 1'b0;
                end
            end
            ST_WALK_CHK:
            begin
                if (cur_hit)
                begin
                    found_next = walk_q_reg + 1'b1;
                    if (!has_prev_reg && cur_is_tail)
                    begin
                        empty_next[walk_q_reg] = 1'b1;
                    end
                end
                else if (cur_is_tail)
                begin
                    if (walk_more)
                    begin
                        walk_q_next = walk_q_reg + 1'b1;
                    end
                    else
                    begin
                        status_next = STATUS_NOT_FOUND;
                    end
                end
                else
                begin
                    walk_prev_next = walk_cur_reg;
                    has_prev_next  = 1'b1;
                end
            end
            ST_WALK_NXT:
            begin
                walk_cur_next = ram_rdata;
            end
            ST_UNLINK:
            begin
                // Bypass the removed entry.
                if (!has_prev_reg)
                begin
                    head_next[walk_q_reg] = ram_rdata;
                end
                else
                begin
                    ram_we = 1'b1;
                    if (cur_is_tail)
                    begin
                        tail_next[walk_q_reg] = walk_prev_reg;
                    end
                end
            end
            ST_PUSH:
            begin
                push_en = 1'b1;
                push_q  = (func_reg == FUNC_SUSPEND) ? Q_SUSP : Q_READY;
                push_id = target_reg;
            end
            ST_DONE:
            begin
                if (rsp_free)
                begin
                    rsp_next.status        = status_reg;
                    rsp_next.given_id      = given_reg;
                    rsp_next.found_in      = found_reg;
                    rsp_next.running_id    = cur_valid_reg ? cur_thread_reg : '0;
                    rsp_next.running_valid = cur_valid_reg;
                    rsp_valid_next         = 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        // Append one ID at a queue tail.
        if (push_en)
        begin
            if (empty_reg[push_q])
            begin
                head_next[push_q]  = push_id;
                empty_next[push_q] = 1'b0;
            end
            else
            begin
                ram_we    = 1'b1;
                ram_waddr = tail_reg[push_q];
                ram_wdata = push_id;
            end
            tail_next[push_q] = push_id;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            empty_reg      <= '1;
            nfree_reg      <= '0;
            cur_thread_reg <= '0;
            cur_valid_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            empty_reg      <= empty_next;
            nfree_reg      <= nfree_next;
            cur_thread_reg <= cur_thread_next;
            cur_valid_reg  <= cur_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        func_reg      <= func_next;
        target_reg    <= target_next;
        status_reg    <= status_next;
        given_reg     <= given_next;
        found_reg     <= found_next;
        walk_q_reg    <= walk_q_next;
        walk_cur_reg  <= walk_cur_next;
        walk_prev_reg <= walk_prev_next;
        has_prev_reg  <= has_prev_next;
        rsp_reg       <= rsp_next;
    end

endmodule

FILE: sv/rrtqs_checker.sv
// Port-level checker for the round-robin thread queue scheduler, with its bind.
`include "assert_macros.svh"

module rrtqs_checker
    import rrtqs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_stall,
    input rrtqs_cmd_t cmd,
    input logic       rsp_valid,
    input logic       rsp_stall,
    input rrtqs_rsp_t rsp
);

    // Hold a stalled result and its payload.
    `ASSERT_HOLD(a_rsp_hold, rsp_valid && rsp_stall, {rsp_valid, rsp}, "stalled result changed")
    // Block the command channel right after a transaction enters.
    `ASSERT_CLK(a_busy_after_cmd, cmd_valid && !cmd_stall |=> cmd_stall, "command taken while busy")
    `ASSERT_CLK(a_idle_id_zero, rsp_valid && !rsp.running_valid |-> rsp.running_id == '0, "running id without running thread")
    `ASSERT_CLK(a_found_ok, rsp_valid && rsp.found_in != FOUND_NONE |-> rsp.status == STATUS_OK, "removal with error status")
    `ASSERT_CLK(a_no_run, rsp_valid && rsp.status == STATUS_NO_RUN |-> !rsp.running_valid, "nothing to run but thread running")

endmodule

bind round_robin_thread_queue_scheduler rrtqs_checker u_rrtqs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
